// File: hdl/sha256_message_hasher_macros.svh
// Assertion macros for the SHA-256 message hasher.
// Included by the top level; no other dependencies.
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: hdl/sha_pkg.sv
// Package for the SHA-256 message hasher: payload types, constants, a rotate function.
// No dependencies.
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_item_type;

   localparam int QueueDepth = 4;

   localparam logic [7:0] PadByte = 8'h80;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   // Classified command from the front end to the back end.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_end;
   } cmd_type;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: hdl/sha_queue.sv
// Short command queue between the front end and the hashing engine.
// Depends on sha_pkg.
module sha_queue
   import sha_pkg::*;
#(
   parameter int Depth = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_data
);
   localparam int AW = $clog2(Depth);

   cmd_type           slot_ff [Depth];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       count_ff, count_in;

   assign full      = (count_ff == (AW+1)'(Depth));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ff];

   // Pointer and count update.
   always_comb begin
      wr_in    = push ? ((wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = pop ? ((rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule

// File: hdl/sha_engine.sv
// Hashing engine: byte packing into the schedule window, padding, one compression round
// per cycle, digest output. Depends on sha_pkg.
module sha_engine
   import sha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ROUND = 6'b000010,
      ST_FOLD  = 6'b000100,
      ST_PAD   = 6'b001000,
      ST_LEN   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   logic [5:0]   fill_ff;
   logic [63:0]  len_ff;
   logic [31:0]  hash_ff [8];
   logic [31:0]  var_ff [8];
   logic [31:0]  w_ff [16];   // message block while filling, schedule window in rounds
   logic [5:0]   round_ff;
   logic         final_ff;   // compression belongs to the end of a message
   logic         pend_ff;    // end mark waits for padding after a full block
   logic         extra_ff;   // another padding block follows this compression
   logic [2:0]   out_ff;
   logic [31:0]  w_cur, s0, s1, t1, t2;

   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_item.digest_word = hash_ff[out_ff];
   assign rsp_item.word_index  = out_ff;
   assign rsp_item.last_word   = (out_ff == 3'd7);

   // Round datapath: schedule word and compression step.
   always_comb begin
      s0 = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_cur = (round_ff < 6'd16) ? w_ff[0] : (w_ff[0] + s0 + w_ff[9] + s1);
      t1 = var_ff[7] + (ror(var_ff[4], 6) ^ ror(var_ff[4], 11) ^ ror(var_ff[4], 25))
         + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6])) + RoundK[round_ff] + w_cur;
      t2 = (ror(var_ff[0], 2) ^ ror(var_ff[0], 13) ^ ror(var_ff[0], 22))
         + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.has_byte && fill_ff == 6'd63) state_in = ST_ROUND;
               else if (cmd.is_end) state_in = ST_PAD;
            end
         end
         ST_ROUND: if (round_ff == 6'd63) state_in = ST_FOLD;
         ST_FOLD: begin
            if (extra_ff) state_in = ST_LEN;
            else if (final_ff) state_in = ST_OUT;
            else if (pend_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_PAD: state_in = ST_ROUND;
         ST_LEN: state_in = ST_ROUND;
         ST_OUT: if (!rsp_stall && out_ff == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         len_ff   <= '0;
         final_ff <= 1'b0;
         pend_ff  <= 1'b0;
         extra_ff <= 1'b0;
         out_ff   <= '0;
         round_ff <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= InitHash[i];
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  // Bytes are packed big-endian straight into the window words.
                  if (cmd.has_byte) begin
                     w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= cmd.data_byte;
                     len_ff  <= len_ff + 64'd8;
                     fill_ff <= fill_ff + 6'd1;
                  end
                  final_ff <= 1'b0;
                  pend_ff  <= cmd.is_end;
                  extra_ff <= 1'b0;
                  if (cmd.has_byte && fill_ff == 6'd63) begin
                     // Full block: start compression with the byte just taken.
                     for (int i = 0; i < 8; i++) var_ff[i] <= hash_ff[i];
                     round_ff <= '0;
                  end
               end
            end
            ST_PAD: begin
               // Place the pad byte, clear the tail, place the length if it fits, decide on an extra block.
               for (int i = 0; i < 16; i++) begin
                  logic [7:0] b [4];
                  for (int j = 0; j < 4; j++) begin
                     if (6'(4*i+j) == fill_ff) b[j] = PadByte;
                     else if (6'(4*i+j) > fill_ff) b[j] = 8'h00;
                     else b[j] = w_ff[i][8*(3-j) +: 8];
                     if (fill_ff < 6'd56 && i >= 14)
                        b[j] = len_ff[8*(7-(4*(i-14)+j)) +: 8];
                  end
                  w_ff[i] <= {b[0], b[1], b[2], b[3]};
               end
               extra_ff <= (fill_ff >= 6'd56);
               final_ff <= 1'b1;
               pend_ff  <= 1'b0;
               for (int i = 0; i < 8; i++) var_ff[i] <= hash_ff[i];
               round_ff <= '0;
            end
            ST_LEN: begin
               // Extra block: zeros and the bit length.
               for (int i = 0; i < 14; i++) w_ff[i] <= '0;
               w_ff[14] <= len_ff[63:32];
               w_ff[15] <= len_ff[31:0];
               extra_ff <= 1'b0;
               for (int i = 0; i < 8; i++) var_ff[i] <= hash_ff[i];
               round_ff <= '0;
            end
            ST_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= w_cur;
               var_ff[7] <= var_ff[6];
               var_ff[6] <= var_ff[5];
               var_ff[5] <= var_ff[4];
               var_ff[4] <= var_ff[3] + t1;
               var_ff[3] <= var_ff[2];
               var_ff[2] <= var_ff[1];
               var_ff[1] <= var_ff[0];
               var_ff[0] <= t1 + t2;
               round_ff <= round_ff + 1'b1;
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + var_ff[i];
               out_ff <= '0;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  out_ff <= out_ff + 1'b1;
                  if (out_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) hash_ff[i] <= InitHash[i];
                     fill_ff <= '0;
                     len_ff  <= '0;
                     final_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// File: hdl/sha256_message_hasher.sv
// SHA-256 over a byte stream. A byte that fills a block starts a compression; an end mark
// starts padding, and with an extra padding block a second compression, before the first
// digest word. The queue takes one byte per cycle unless it is full; the single shared
// round unit holds byte intake while it compresses a block.
// Reset (synchronous, active high) empties the queue and restores the initial hash.
// Depends on sha_pkg, sha_queue, sha_engine and the assertion macros header.
`include "sha256_message_hasher_macros.svh"
module sha256_message_hasher
   import sha_pkg::*;
#(
   parameter int QDepth = QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);
   logic    q_full, q_ne, q_pop, q_push;
   cmd_type q_in, q_out;

   // Front end: classify items; items with neither flag are dropped.
   assign req_stall       = q_full;
   assign q_push          = req_valid && !q_full &&
                            (req_item.byte_present || req_item.message_end);
   assign q_in.data_byte  = req_item.data_byte;
   assign q_in.has_byte   = req_item.byte_present;
   assign q_in.is_end     = req_item.message_end;

   sha_queue #(.Depth(QDepth)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_ne), .pop_data(q_out));

   sha_engine u_engine (
      .clock(clock), .reset(reset), .cmd_valid(q_ne), .cmd(q_out), .cmd_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item));

   `SHA_ASSERT_IMP(a_pop_needs_data, q_pop, q_ne)
   `SHA_ASSERT_IMP(a_last_is_seven, rsp_valid && rsp_item.last_word, rsp_item.word_index == 3'd7)
   `SHA_ASSERT_NEXT(a_word_advances, rsp_valid && !rsp_stall && !rsp_item.last_word,
      rsp_valid && rsp_item.word_index == $past(rsp_item.word_index) + 3'd1)
endmodule

// File: tb/sha256_message_hasher_tb.sv
// Testbench for the SHA-256 message hasher: drives byte items, predicts digests.
// Depends on sha_pkg and the sha256_message_hasher top level.
`timescale 1ns / 1ps
module sha256_message_hasher_tb
   import sha_pkg::*;
();

   // Digest predictor and store of expected digest words.
   class digest_scoreboard;
      logic [31:0] hash_state [8];
      logic [7:0]  block_bytes [64];
      int          fill_count;
      logic [63:0] length_bits;
      rsp_item_type pending_words [$];
      int mismatches;
      int words_checked;
      int messages_done;

      function void restart();
         for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
         for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
         fill_count = 0;
         length_bits = 64'd0;
      endfunction

      function logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // One 64-round compression of the buffered block into hash_state.
      function void compress();
         logic [31:0] sched [64];
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
         for (int i = 0; i < 16; i++)
            sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
         for (int i = 16; i < 64; i++) begin
            s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
         end
         a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
         e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
         for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + RoundK[i] + sched[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
         end
         hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
         hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
      endfunction

      // Notes an accepted input item and queues any digest words it causes.
      function void note_item(req_item_type it);
         rsp_item_type w;
         if (it.byte_present) begin
            block_bytes[fill_count] = it.data_byte;
            length_bits += 64'd8;
            fill_count++;
            if (fill_count == 64) begin
               compress();
               fill_count = 0;
            end
         end
         if (!it.message_end) return;
         block_bytes[fill_count] = PadByte;
         for (int i = fill_count + 1; i < 64; i++) block_bytes[i] = 8'h00;
         if (fill_count >= 56) begin
            compress();
            for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) block_bytes[56+i] = length_bits[8*(7-i) +: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            w.digest_word = hash_state[i];
            w.word_index  = 3'(i);
            w.last_word   = (i == 7);
            pending_words = {pending_words, w};
         end
         messages_done++;
         restart();
      endfunction

      // Compares one accepted digest word with the oldest expectation.
      function void check_word(rsp_item_type got);
         rsp_item_type want;
         words_checked++;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected digest word %h", got);
            return;
         end
         want = pending_words.pop_front();
         if (got.digest_word !== want.digest_word || got.word_index !== want.word_index
             || got.last_word !== want.last_word) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected word %h index %0d last %b, got %h index %0d last %b",
                        want.digest_word, want.word_index, want.last_word,
                        got.digest_word, got.word_index, got.last_word);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   digest_scoreboard board = new();
   int  hold_off_cycles = 0;
   int  recv_wait = 0;
   bit  stimulus_done = 1'b0;

   sha256_message_hasher uut (.*);

   always #5 clock = ~clock;

   // Sends one item after a random gap; returns once it is accepted.
   task automatic send_item(input logic [7:0] data, input logic present, input logic last,
                            input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{data_byte: data, byte_present: present, message_end: last};
      do @(posedge clock); while (req_stall);
      board.note_item('{data_byte: data, byte_present: present, message_end: last});
   endtask

   // Sends a well-formed message of the given length with random bytes.
   task automatic send_message(input int len, input bit end_alone);
      for (int i = 0; i < len; i++)
         send_item(8'($urandom), 1'b1, (!end_alone && i == len - 1));
      if (end_alone || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // Stops offering items and waits until every expected word has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_words.size() != 0) @(posedge clock);
   endtask

   // Receiver: a random wait after each word, and a long hold-off when requested.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_word(rsp_item);
         recv_wait = stimulus_done ? 0 : int'($urandom_range(0, 3));
      end
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (recv_wait > 0) begin
         recv_wait = recv_wait - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      board.restart();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty message, "abc", end alone and idle items.
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'haa, 1'b0, 1'b1);
      send_item(8'h55, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b1);

      // Sender pause until every expected word has arrived.
      wait_drained();

      // Long receiver hold-off while the sender offers a full block and more; then boundary lengths.
      hold_off_cycles = 400;
      send_message(64, 1'b0);
      send_message(3, 1'b0);
      send_message(55, 1'b0);
      wait_drained();
      send_message(56, 1'b1);
      send_message(63, 1'b0);

      // Random messages: mostly short, some a little longer, some noise.
      while (board.messages_done < 20) begin
         case ($urandom_range(0, 5))
            0: send_item(8'($urandom), 1'b0, 1'b0);
            1: send_message(int'($urandom_range(10, 20)), 1'($urandom_range(0, 1)));
            default: send_message(int'($urandom_range(0, 9)), 1'($urandom_range(0, 1)));
         endcase
      end

      stimulus_done = 1'b1;
      wait_drained();
      repeat (200) @(posedge clock);
      $display("Covered %0d messages and %0d digest words, including padding-block and",
               board.messages_done, board.words_checked);
      $display("end-only cases, idle items and a long result-side hold-off.");
      if (board.mismatches == 0 && board.pending_words.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
